>>> rtl/hlcp_pkg.sv
package hlcp_pkg;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned CmpLen     = 6;
  localparam int unsigned PrefixLen  = 6;
  localparam int unsigned ColourW    = 31;
  localparam int unsigned NumColours = 3;
  localparam int unsigned SegMax     = 4;

  localparam logic [ColourW-1:0] SatMax = {ColourW{1'b1}};

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_start;
  } hlcp_in_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         mode_code;
    logic [ColourW-1:0] red_value;
    logic [ColourW-1:0] green_value;
    logic [ColourW-1:0] blue_value;
  } hlcp_out_t;

  typedef enum logic [2:0] {
    PhIdle   = 3'b001,
    PhPrefix = 3'b010,
    PhPath   = 3'b100
  } hlcp_phase_e;

  // Characters of "POST /"
  function automatic logic [7:0] prefix_char(input logic [2:0] p);
    logic [7:0] ch;
    case (p)
      3'd0:    ch = 8'h50;
      3'd1:    ch = 8'h4f;
      3'd2:    ch = 8'h53;
      3'd3:    ch = 8'h54;
      3'd4:    ch = 8'h20;
      3'd5:    ch = 8'h2f;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Mode words: off, basis, schizm, blinde(r), pulsar
  function automatic logic [7:0] word_char(input logic [2:0] k, input logic [2:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      3'd0: case (p)
        3'd0: ch = 8'h6f; 3'd1: ch = 8'h66; 3'd2: ch = 8'h66;
        default: ch = 8'h00;
      endcase
      3'd1: case (p)
        3'd0: ch = 8'h62; 3'd1: ch = 8'h61; 3'd2: ch = 8'h73;
        3'd3: ch = 8'h69; 3'd4: ch = 8'h73;
        default: ch = 8'h00;
      endcase
      3'd2: case (p)
        3'd0: ch = 8'h73; 3'd1: ch = 8'h63; 3'd2: ch = 8'h68;
        3'd3: ch = 8'h69; 3'd4: ch = 8'h7a; 3'd5: ch = 8'h6d;
        default: ch = 8'h00;
      endcase
      3'd3: case (p)
        3'd0: ch = 8'h62; 3'd1: ch = 8'h6c; 3'd2: ch = 8'h69;
        3'd3: ch = 8'h6e; 3'd4: ch = 8'h64; 3'd5: ch = 8'h65;
        default: ch = 8'h00;
      endcase
      3'd4: case (p)
        3'd0: ch = 8'h70; 3'd1: ch = 8'h75; 3'd2: ch = 8'h6c;
        3'd3: ch = 8'h73; 3'd4: ch = 8'h61; 3'd5: ch = 8'h72;
        default: ch = 8'h00;
      endcase
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] word_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      3'd0:    n = 3'd3;
      3'd1:    n = 3'd5;
      default: n = 3'd6;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/http_post_light_command_parser.sv
// Channel | Handshake                 | Payload
// input   | in_valid_i / in_ready_o   | in_data_i  (hlcp_in_t: char_in, line_start)
// output  | out_valid_o / out_ready_i | out_data_o (hlcp_out_t: accepted, mode, colours)
//
// One byte per cycle unless the output buffer is full: a transfer lands in the
// input register, the parser updates its line state from it when it advances and,
// at a space or a prefix mismatch, writes one result into a two-entry output buffer.
// Reset (rst_ni low, asynchronous) empties both stages and leaves the parser
// idle, waiting for a byte flagged line_start.
// A full output buffer holds the input register; input stays ready while the
// register is empty or able to advance.
module http_post_light_command_parser import hlcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hlcp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hlcp_out_t out_data_o
);

  logic      s1_valid_q, s1_valid_d;
  hlcp_in_t  s1_data_q;
  logic      buf_full;
  logic      advance;
  logic      in_xfer;
  logic      res_valid;
  hlcp_out_t res;

  // advance the held byte into the parser whenever a result has room
  assign advance    = s1_valid_q && !buf_full;
  assign in_ready_o = !s1_valid_q || !buf_full;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer)      s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) s1_data_q <= in_data_i;
  end

  hlcp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (s1_data_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // drop results only through the buffer; it never overfills as advance waits
  hlcp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (advance && res_valid),
    .wr_data_i   (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/hlcp_parse.sv
module hlcp_parse import hlcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  hlcp_in_t  item_i,
  output logic      res_valid_o,
  output hlcp_out_t res_o
);

  hlcp_phase_e        phase_q, phase_d, phase_b;
  logic [2:0]         ppos_q, ppos_d, ppos_b;
  logic [2:0]         seg_q, seg_d, seg_b;
  logic [2:0]         kpos_q, kpos_d, kpos_b;
  logic [4:0]         cand_q, cand_d, cand_b;
  logic [ColourW-1:0] acc_q [NumColours];
  logic [ColourW-1:0] acc_b [NumColours];
  logic [ColourW-1:0] acc_d [NumColours];
  logic               ended_q, ended_d, ended_b;

  logic [7:0]         ch;
  logic [1:0]         cidx;
  logic [ColourW-1:0] acc_sel;
  logic [ColourW+3:0] prod;
  logic [2:0]         mode;

  assign ch = item_i.char_in;

  always_comb begin
    // a new line clears everything before this byte is looked at
    if (item_i.line_start) begin
      phase_b = PhPrefix;
      ppos_b  = '0;
      seg_b   = '0;
      kpos_b  = '0;
      cand_b  = '1;
      ended_b = 1'b0;
      for (int i = 0; i < NumColours; i++) acc_b[i] = '0;
    end else begin
      phase_b = phase_q;
      ppos_b  = ppos_q;
      seg_b   = seg_q;
      kpos_b  = kpos_q;
      cand_b  = cand_q;
      ended_b = ended_q;
      for (int i = 0; i < NumColours; i++) acc_b[i] = acc_q[i];
    end

    cidx    = seg_b[1:0] - 2'd1;
    acc_sel = acc_b[cidx];
    prod    = ({4'b0, acc_sel} << 3) + ({4'b0, acc_sel} << 1) + {31'b0, ch[3:0] - ChZero[3:0]};

    mode = 3'd0;
    for (int k = NumWords - 1; k >= 0; k--) begin
      if (cand_b[k] && (kpos_b >= word_len(3'(k)))) mode = 3'(k);
    end

    phase_d = phase_b;
    ppos_d  = ppos_b;
    seg_d   = seg_b;
    kpos_d  = kpos_b;
    cand_d  = cand_b;
    ended_d = ended_b;
    for (int i = 0; i < NumColours; i++) acc_d[i] = acc_b[i];

    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_b)
      PhPrefix: begin
        if ((ppos_b < 3'(PrefixLen)) && (prefix_char(ppos_b) == ch)) begin
          ppos_d = ppos_b + 3'd1;
          if (ppos_d == 3'(PrefixLen)) phase_d = PhPath;
        end else begin
          phase_d     = PhIdle;
          res_valid_o = 1'b1;
        end
      end
      PhPath: begin
        if (ch == ChSpace) begin
          phase_d           = PhIdle;
          res_valid_o       = 1'b1;
          res_o.accepted    = 1'b1;
          res_o.mode_code   = mode;
          res_o.red_value   = acc_b[0];
          res_o.green_value = acc_b[1];
          res_o.blue_value  = acc_b[2];
        end else if (ch == ChSlash) begin
          if (seg_b < 3'(SegMax)) seg_d = seg_b + 3'd1;
          ended_d = 1'b0;
        end else if (seg_b == 3'd0) begin
          for (int k = 0; k < NumWords; k++) begin
            if (kpos_b >= 3'(CmpLen)) begin
              if (word_len(3'(k)) < 3'(CmpLen)) cand_d[k] = 1'b0;
            end else if (kpos_b >= word_len(3'(k))) begin
              cand_d[k] = 1'b0;
            end else if (word_char(3'(k), kpos_b) != ch) begin
              cand_d[k] = 1'b0;
            end
          end
          if (kpos_b < 3'(CmpLen)) kpos_d = kpos_b + 3'd1;
        end else if ((seg_b <= 3'd3) && !ended_b) begin
          if (ch inside {[ChZero:ChNine]}) begin
            // saturate on overflow of 31 bits
            acc_d[cidx] = (prod > {4'b0, SatMax}) ? SatMax : prod[ColourW-1:0];
          end else begin
            ended_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      ppos_q  <= '0;
      seg_q   <= '0;
      kpos_q  <= '0;
      cand_q  <= '1;
      ended_q <= 1'b0;
      for (int i = 0; i < NumColours; i++) acc_q[i] <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      ppos_q  <= ppos_d;
      seg_q   <= seg_d;
      kpos_q  <= kpos_d;
      cand_q  <= cand_d;
      ended_q <= ended_d;
      for (int i = 0; i < NumColours; i++) acc_q[i] <= acc_d[i];
    end
  end

endmodule

>>> rtl/hlcp_out_buf.sv
module hlcp_out_buf import hlcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  hlcp_out_t wr_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hlcp_out_t out_data_o
);

  hlcp_out_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       rd;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign rd          = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_i) wr_ptr_q <= ~wr_ptr_q;
      if (rd)   rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd};
    end
  end

endmodule

>>> sim/http_post_light_command_parser_tb.sv
`timescale 1ns / 1ps

module http_post_light_command_parser_tb;
  import hlcp_pkg::*;

  localparam int unsigned HoldOff     = 300;  // one long receiver hold-off
  localparam int unsigned StallLimit  = 2000; // cycles with no transfer before giving up
  localparam int unsigned TailCycles  = 20;   // settle time once nothing is expected
  localparam int unsigned RandomBytes = 400;  // parsed bytes in the random part

  // Mode codes as they appear in mode_code
  localparam logic [2:0] ModeOff     = 3'd0;
  localparam logic [2:0] ModeBasis   = 3'd1;
  localparam logic [2:0] ModeSchizm  = 3'd2;
  localparam logic [2:0] ModeBlinder = 3'd3;
  localparam logic [2:0] ModePulsar  = 3'd4;

  localparam hlcp_out_t Rejected = '0;

  typedef struct {
    string     text;
    bit        starts;   // line_start on the first byte
    int        zero_at;  // byte replaced by zero, -1 for none
    bit        typed;    // take want as the expectation
    hlcp_out_t want;
  } line_vector_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  hlcp_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  hlcp_out_t out_data;

  // Parser state mirrored by the predictor
  hlcp_phase_e          phase;
  int unsigned          pfx_pos;
  int unsigned          seg_idx;
  int unsigned          kw_pos;
  logic [NumWords-1:0]  kw_alive;
  logic [ColourW-1:0]   colour [NumColours];
  bit                   digits_done;

  string        post_prefix = "POST /";
  hlcp_out_t    pending_results [$];
  hlcp_in_t     line_q [$];
  line_vector_t vectors [$];

  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned parsed_bytes = 0;

  always #5 clk_i = ~clk_i;

  http_post_light_command_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  task automatic note_failure(input string msg);
    fail_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic hlcp_out_t make_result(input logic acc, input logic [2:0] mode,
                                            input logic [ColourW-1:0] r,
                                            input logic [ColourW-1:0] g,
                                            input logic [ColourW-1:0] b);
    hlcp_out_t res;
    res.accepted    = acc;
    res.mode_code   = mode;
    res.red_value   = r;
    res.green_value = g;
    res.blue_value  = b;
    return res;
  endfunction

  // Full spelling of each mode word; only the first CmpLen characters count
  function automatic string mode_word(input logic [2:0] k);
    case (k)
      ModeOff:     return "off";
      ModeBasis:   return "basis";
      ModeSchizm:  return "schizm";
      ModeBlinder: return "blinder";
      ModePulsar:  return "pulsar";
      default:     return "";
    endcase
  endfunction

  function automatic void clear_line();
    pfx_pos     = 0;
    seg_idx     = 0;
    kw_pos      = 0;
    kw_alive    = '1;
    digits_done = 1'b0;
    foreach (colour[i]) colour[i] = '0;
  endfunction

  // Advance the mirrored parser by one byte; return 1 when the byte yields a result
  function automatic bit parse_byte(input hlcp_in_t b, output hlcp_out_t res);
    string       w;
    int unsigned wl;
    int unsigned ci;
    bit          keep;
    logic [63:0] acc;
    res = '0;
    if (b.line_start) begin
      clear_line();
      phase = PhPrefix;
    end
    if (phase == PhPrefix) begin
      if (b.char_in == post_prefix[pfx_pos]) begin
        pfx_pos++;
        if (pfx_pos == PrefixLen) phase = PhPath;
        return 1'b0;
      end
      // first differing byte: reject and drop everything up to the next line start
      phase = PhIdle;
      return 1'b1;
    end
    if (phase != PhPath) return 1'b0;

    if (b.char_in == ChSpace) begin
      phase         = PhIdle;
      res.accepted  = 1'b1;
      res.mode_code = ModeOff;
      // walk downwards so that the lowest surviving word wins
      for (int k = NumWords - 1; k >= 0; k--) begin
        w  = mode_word(3'(k));
        wl = (w.len() > CmpLen) ? CmpLen : w.len();
        if (kw_alive[k] && kw_pos >= wl) res.mode_code = 3'(k);
      end
      res.red_value   = colour[0];
      res.green_value = colour[1];
      res.blue_value  = colour[2];
      return 1'b1;
    end

    if (b.char_in == ChSlash) begin
      if (seg_idx < SegMax) seg_idx++;
      digits_done = 1'b0;
      return 1'b0;
    end

    if (seg_idx == 0) begin
      for (int k = 0; k < NumWords; k++) begin
        w  = mode_word(3'(k));
        wl = (w.len() > CmpLen) ? CmpLen : w.len();
        if (kw_pos >= CmpLen) keep = (wl >= CmpLen);
        else if (kw_pos >= wl) keep = 1'b0;
        else keep = (b.char_in == w[kw_pos]);
        if (!keep) kw_alive[k] = 1'b0;
      end
      if (kw_pos < CmpLen) kw_pos++;
    end else if (seg_idx <= NumColours && !digits_done) begin
      ci = seg_idx - 1;
      if (b.char_in < ChZero || b.char_in > ChNine) begin
        digits_done = 1'b1;
      end else begin
        acc        = 64'(colour[ci]) * 10 + 64'(b.char_in - ChZero);
        colour[ci] = (acc > 64'(SatMax)) ? SatMax : acc[ColourW-1:0];
      end
    end
    return 1'b0;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void put_char(input logic [7:0] ch);
    hlcp_in_t b;
    b.char_in    = ch;
    b.line_start = 1'b0;
    line_q.push_back(b);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  // Any byte but space and slash, leaning towards digits and lower case
  function automatic logic [7:0] path_char();
    logic [7:0] ch;
    case ($urandom_range(0, 9))
      0:          ch = 8'h00;
      1, 2, 3, 4: ch = 8'(ChZero + $urandom_range(0, 9));
      5, 6, 7:    ch = 8'($urandom_range(8'h61, 8'h7a));
      default:    ch = 8'($urandom_range(0, 255));
    endcase
    if (ch == ChSpace || ch == ChSlash) ch = 8'h2d;
    return ch;
  endfunction

  // Fill line_q with one random request line: mostly well-formed, some broken
  function automatic void build_random_line(output bit starts);
    string       w;
    int unsigned kind;
    int unsigned cut;
    int unsigned segs;
    int unsigned n;
    logic [7:0]  ch;
    line_q.delete();
    starts = 1'b1;
    kind   = $urandom_range(0, 99);
    if (kind < 12) begin
      // prefix that breaks off at a random byte
      cut = $urandom_range(0, PrefixLen - 1);
      for (int i = 0; i < cut; i++) put_char(post_prefix[i]);
      ch = 8'($urandom_range(0, 255));
      if (ch == post_prefix[cut]) ch ^= 8'h20;
      put_char(ch);
      repeat ($urandom_range(0, 6)) put_char(8'($urandom_range(0, 255)));
    end else if (kind < 22) begin
      // raw noise with the odd line start scattered through it
      starts = $urandom_range(0, 1);
      repeat ($urandom_range(1, 12)) put_char(8'($urandom_range(0, 255)));
      foreach (line_q[i]) if (i != 0 && $urandom_range(0, 9) == 0) line_q[i].line_start = 1'b1;
    end else begin
      put_text(post_prefix);
      w = mode_word(3'($urandom_range(0, NumWords - 1)));
      case ($urandom_range(0, 5))
        0, 1: put_text(w);
        2: begin
          put_text(w);
          repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(8'h61, 8'h7a)));
        end
        3: begin
          cut = $urandom_range(0, w.len() - 1);
          for (int i = 0; i < cut; i++) put_char(w[i]);
        end
        4: begin
          cut = $urandom_range(0, w.len() - 1);
          for (int i = 0; i < w.len(); i++)
            put_char((i == cut) ? 8'($urandom_range(8'h61, 8'h7a)) : w[i]);
        end
        default: repeat ($urandom_range(0, 8)) put_char(path_char());
      endcase
      segs = ($urandom_range(0, 9) < 6) ? NumColours : $urandom_range(0, 6);
      for (int s = 1; s <= segs; s++) begin
        put_char(ChSlash);
        if (s <= NumColours) begin
          case ($urandom_range(0, 9))
            0:             n = 0;
            1, 2, 3, 4, 5: n = $urandom_range(1, 4);
            6, 7:          n = $urandom_range(5, 9);
            default:       n = $urandom_range(10, 12);
          endcase
          repeat (n) put_char(8'(ChZero + $urandom_range(0, 9)));
          if ($urandom_range(0, 4) == 0) begin
            put_char(($urandom_range(0, 1) == 0) ? 8'h2b : 8'($urandom_range(8'h61, 8'h7a)));
            repeat ($urandom_range(0, 3)) put_char(path_char());
          end
        end else begin
          repeat ($urandom_range(0, 4)) put_char(path_char());
        end
      end
      // abandoned lines stop short of the space; the next line start cuts them off
      if (kind < 90) begin
        put_char(ChSpace);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 8)) put_char(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // Offer line_q byte by byte; predict on each transfer
  task automatic send_line(input bit starts, input bit typed, input hlcp_out_t want);
    hlcp_in_t    b;
    hlcp_out_t   got;
    bit          steady;
    int unsigned gap;
    steady = ($urandom_range(0, 4) == 0);
    if (line_q.size() != 0) line_q[0].line_start = starts;
    foreach (line_q[i]) begin
      b   = line_q[i];
      gap = steady ? 0 : idle_span();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      // valid may already be high from the last transfer; keep it there
      in_valid <= 1'b1;
      in_data  <= b;
      do @(posedge clk_i); while (!in_ready);
      if (b.line_start || phase != PhIdle) parsed_bytes++;
      if (parse_byte(b, got)) pending_results.push_back(typed ? want : got);
      @(negedge clk_i);
    end
  endtask

  function automatic void add_row(input string text, input bit starts, input int zero_at,
                                  input bit typed, input hlcp_out_t want);
    line_vector_t v;
    v.text    = text;
    v.starts  = starts;
    v.zero_at = zero_at;
    v.typed   = typed;
    v.want    = want;
    vectors.push_back(v);
  endfunction

  // Check each output transfer against the oldest expectation, and watch for a hang
  always @(posedge clk_i) begin : watch
    hlcp_out_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result with nothing expected: %p", out_data));
        end else begin
          want = pending_results.pop_front();
          if (out_data.accepted != want.accepted)
            note_failure($sformatf("accepted %0d, expected %0d",
                                   out_data.accepted, want.accepted));
          if (out_data.mode_code != want.mode_code)
            note_failure($sformatf("mode_code %0d, expected %0d",
                                   out_data.mode_code, want.mode_code));
          if (out_data.red_value != want.red_value)
            note_failure($sformatf("red_value %0d, expected %0d",
                                   out_data.red_value, want.red_value));
          if (out_data.green_value != want.green_value)
            note_failure($sformatf("green_value %0d, expected %0d",
                                   out_data.green_value, want.green_value));
          if (out_data.blue_value != want.blue_value)
            note_failure($sformatf("blue_value %0d, expected %0d",
                                   out_data.blue_value, want.blue_value));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("http_post_light_command_parser_tb failed");
          $finish;
        end
      end
    end
  end

  // Receiver: random ready pattern, plus one long hold-off that backs the block up
  initial begin : sink
    bit          held;
    bit          level;
    int unsigned span;
    held      = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && results_seen >= 6) begin
        // hold long enough for the output buffer and input register to fill
        held  = 1'b1;
        level = 1'b0;
        span  = HoldOff;
      end else if ($urandom_range(0, 99) < 65) begin
        level = 1'b1;
        span  = $urandom_range(1, 16);
      end else begin
        level = 1'b0;
        span  = idle_span() + 1;
      end
      out_ready <= level;
      repeat (span) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    bit starts;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    phase    = PhIdle;
    clear_line();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lines: every mode, saturation, missing segments, rejects,
    // bytes while idle, abandoned lines and a zero byte inside a number
    add_row("POST /off/1/2/3 ", 1, -1, 1, make_result(1, ModeOff, 1, 2, 3));
    add_row("POST /basis/255/128/0 ", 1, -1, 1, make_result(1, ModeBasis, 255, 128, 0));
    add_row("POST /schizm/0/0/0 ", 1, -1, 1, make_result(1, ModeSchizm, 0, 0, 0));
    add_row("POST /blinder/7/8/9 ", 1, -1, 1, make_result(1, ModeBlinder, 7, 8, 9));
    add_row("POST /pulsar/2147483647/2147483648/99999999999 ", 1, -1, 1,
            make_result(1, ModePulsar, SatMax, SatMax, SatMax));
    add_row("POST /basis ", 1, -1, 1, make_result(1, ModeBasis, 0, 0, 0));
    add_row("POST / ", 1, -1, 1, make_result(1, ModeOff, 0, 0, 0));
    add_row("POST /offf/3/4/5/6/7 ", 1, -1, 1, make_result(1, ModeOff, 3, 4, 5));
    add_row("POST /off/1 /2/3 x", 1, -1, 1, make_result(1, ModeOff, 1, 0, 0));
    add_row("GET /off ", 1, -1, 1, Rejected);
    add_row("zz POST /off ", 0, -1, 0, '0);
    add_row("POST x/1 ", 1, -1, 1, Rejected);
    add_row("POST /schizmatic/12x34/-5/+6 ", 1, -1, 0, '0);
    add_row("POST /blinde/1/2/3 ", 1, -1, 0, '0);
    add_row("POST /pulsa/4/5/6 ", 1, -1, 0, '0);
    add_row("POST /bas", 1, -1, 0, '0);
    add_row("PO", 1, -1, 0, '0);
    add_row("POST /off/12#4/5 ", 1, 12, 0, '0);
    add_row("POST ///// ", 1, -1, 0, '0);
    add_row("POST /off/000000000001/0099/x ", 1, -1, 0, '0);

    foreach (vectors[i]) begin
      line_q.delete();
      put_text(vectors[i].text);
      if (vectors[i].zero_at >= 0) line_q[vectors[i].zero_at].char_in = 8'h00;
      send_line(vectors[i].starts, vectors[i].typed, vectors[i].want);
    end

    parsed_bytes = 0;
    while (parsed_bytes < RandomBytes) begin
      build_random_line(starts);
      send_line(starts, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then give a late stray result time to show up
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("http_post_light_command_parser_tb passed");
    end else begin
      $display("http_post_light_command_parser_tb failed");
    end
    $finish;
  end

endmodule

>>> http_post_light_command_parser.f
rtl/hlcp_pkg.sv
rtl/hlcp_parse.sv
rtl/hlcp_out_buf.sv
rtl/http_post_light_command_parser.sv
sim/http_post_light_command_parser_tb.sv
